// File: hw/rtl/drmt_pkg.sv
// Package with the item types, command codes and constants of the dirty rectangle table.
`timescale 1ns / 1ps

package drmt_pkg;

    // Default table depth.
    localparam int MAX_RECTS_DEF = 8;

    // Command codes.
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_CLIP  = 2'd1;
    localparam logic [1:0] CMD_MERGE = 2'd2;
    localparam logic [1:0] CMD_READ  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Reset values of the screen size registers.
    localparam logic [14:0] WIDTH_RESET  = 15'd320;
    localparam logic [14:0] HEIGHT_RESET = 15'd240;

    // One rectangle with inclusive corners.
    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] r;
        logic signed [15:0] b;
    } t_box;

    // One input item.
    typedef struct packed {
        logic [1:0]         command;
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic signed [15:0] right;
        logic signed [15:0] bottom;
        logic [2:0]         slot;
    } t_item;

    // One result item.
    typedef struct packed {
        logic               accepted;
        logic [3:0]         entry_count;
        logic               entry_valid;
        logic signed [15:0] out_left;
        logic signed [15:0] out_top;
        logic signed [15:0] out_right;
        logic signed [15:0] out_bottom;
    } t_result;

    // Outputs of the shared rectangle unit.
    typedef struct packed {
        logic near;
        t_box joined;
        t_box clamped;
        logic empty;
    } t_unit_res;

endpackage

// File: hw/rtl/drmt_box_unit.sv
// Shared rectangle unit: touch test, union and clipping of one entry.
`timescale 1ns / 1ps

module drmt_box_unit (
    input  drmt_pkg::t_box      i_a,
    input  drmt_pkg::t_box      i_b,
    input  logic [14:0]         i_width,
    input  logic [14:0]         i_height,
    output drmt_pkg::t_unit_res o_res
);

    logic signed [16:0] a_l, a_t, a_r, a_b;
    logic signed [16:0] b_l, b_t, b_r, b_b;
    logic signed [16:0] w_ext, h_ext, w_m1, h_m1;
    drmt_pkg::t_box     clamped;

    // Extend the corners by one bit so that adding the one pixel gap cannot overflow.
    assign a_l = {i_a.l[15], i_a.l};
    assign a_t = {i_a.t[15], i_a.t};
    assign a_r = {i_a.r[15], i_a.r};
    assign a_b = {i_a.b[15], i_a.b};
    assign b_l = {i_b.l[15], i_b.l};
    assign b_t = {i_b.t[15], i_b.t};
    assign b_r = {i_b.r[15], i_b.r};
    assign b_b = {i_b.b[15], i_b.b};

    // Two boxes touch when no side is more than one pixel clear of the other box.
    assign o_res.near = !(((a_r + 17'sd1) < b_l) || ((b_r + 17'sd1) < a_l) ||
                          ((a_b + 17'sd1) < b_t) || ((b_b + 17'sd1) < a_t));

    // Union of the two boxes.
    assign o_res.joined.l = (i_a.l < i_b.l) ? i_a.l : i_b.l;
    assign o_res.joined.t = (i_a.t < i_b.t) ? i_a.t : i_b.t;
    assign o_res.joined.r = (i_a.r > i_b.r) ? i_a.r : i_b.r;
    assign o_res.joined.b = (i_a.b > i_b.b) ? i_a.b : i_b.b;

    // Clip the first box to the screen.
    assign w_ext = {2'b00, i_width};
    assign h_ext = {2'b00, i_height};
    assign w_m1  = w_ext - 17'sd1;
    assign h_m1  = h_ext - 17'sd1;

    assign clamped.l = i_a.l[15] ? 16'sd0 : i_a.l;
    assign clamped.t = i_a.t[15] ? 16'sd0 : i_a.t;
    assign clamped.r = (a_r >= w_ext) ? w_m1[15:0] : i_a.r;
    assign clamped.b = (a_b >= h_ext) ? h_m1[15:0] : i_a.b;

    assign o_res.clamped = clamped;
    assign o_res.empty   = (clamped.r < clamped.l) || (clamped.b < clamped.t);

endmodule

// File: hw/rtl/drmt_seq.sv
// Command sequencer with the rectangle table memory.
`timescale 1ns / 1ps

module drmt_seq #(
    parameter int MAX_RECTS = drmt_pkg::MAX_RECTS_DEF,
    parameter int CW        = $clog2(MAX_RECTS + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  drmt_pkg::t_item   i_item,
    input  logic [14:0]       i_width,
    input  logic [14:0]       i_height,
    output logic              o_busy,
    output logic [CW-1:0]     o_count,
    output logic              o_done,
    output drmt_pkg::t_result o_res
);

    localparam int IW = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_CHK,
        S_FULL_RD,
        S_FULL_ACC,
        S_CLIP_RD,
        S_CLIP_CHK,
        S_MRG_RD,
        S_MRG_CHK,
        S_MRG_MOVE,
        S_RD_OUT
    } t_state;

    t_state              r_state, n_state;
    logic [CW-1:0]       r_i, n_i;
    logic [CW-1:0]       r_j, n_j;
    logic [CW-1:0]       r_count, n_count;
    drmt_pkg::t_box      r_acc, n_acc;
    logic                r_flag, n_flag;

    // Table memory with two registered read ports and one write port.
    drmt_pkg::t_box      mem [MAX_RECTS];
    drmt_pkg::t_box      r_rd_a, r_rd_b;
    logic                mem_we;
    logic [IW-1:0]       mem_wa, rd_addr_a, rd_addr_b;
    drmt_pkg::t_box      mem_wd;

    logic [CW-1:0]       cnt_m1;
    logic [31:0]         slot_ext;
    drmt_pkg::t_box      unit_b;
    drmt_pkg::t_unit_res unit;
    drmt_pkg::t_result   res;
    logic                done;

    assign cnt_m1   = r_count - CW'(1);
    assign slot_ext = 32'(i_item.slot);

    // The second operand is the other table entry while merging, else the held box.
    assign unit_b = (r_state == S_MRG_CHK) ? r_rd_b : r_acc;

    drmt_box_unit u_box (
        .i_a      (r_rd_a),
        .i_b      (unit_b),
        .i_width  (i_width),
        .i_height (i_height),
        .o_res    (unit)
    );

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
    end

    // Next state, table accesses and the result of the finishing step.
    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_count   = r_count;
        n_acc     = r_acc;
        n_flag    = r_flag;
        mem_we    = 1'b0;
        mem_wa    = r_i[IW-1:0];
        mem_wd    = r_acc;
        rd_addr_a = r_i[IW-1:0];
        rd_addr_b = r_j[IW-1:0];
        done      = 1'b0;
        res       = '0;
        res.accepted = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_item.command)
                        drmt_pkg::CMD_ADD: begin
                            n_acc.l = i_item.left;
                            n_acc.t = i_item.top;
                            n_acc.r = i_item.right;
                            n_acc.b = i_item.bottom;
                            n_flag  = (i_item.right < i_item.left) ||
                                      (i_item.bottom < i_item.top);
                            n_i     = '0;
                            n_state = S_ADD_RD;
                        end
                        drmt_pkg::CMD_CLIP: begin
                            n_i     = '0;
                            n_state = S_CLIP_RD;
                        end
                        drmt_pkg::CMD_MERGE: begin
                            n_i     = '0;
                            n_j     = CW'(1);
                            n_state = S_MRG_RD;
                        end
                        drmt_pkg::CMD_READ: begin
                            rd_addr_a = slot_ext[IW-1:0];
                            n_flag    = (slot_ext < 32'(r_count)) && (slot_ext < MAX_RECTS);
                            n_state   = S_RD_OUT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            // Reject an inverted box, else scan the entries for one that touches it, else append it.
            S_ADD_RD: begin
                if (r_flag) begin
                    res.accepted = 1'b0;
                    done         = 1'b1;
                    n_state      = S_IDLE;
                end else if (r_i < r_count) begin
                    n_state = S_ADD_CHK;
                end else if (32'(r_count) < MAX_RECTS) begin
                    mem_we  = 1'b1;
                    mem_wa  = r_count[IW-1:0];
                    mem_wd  = r_acc;
                    n_count = r_count + CW'(1);
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_i     = '0;
                    n_state = S_FULL_RD;
                end
            end

            S_ADD_CHK: begin
                if (unit.near) begin
                    mem_we  = 1'b1;
                    mem_wd  = unit.joined;
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_state = S_ADD_RD;
                end
            end

            // Full table: fold every entry into the held box, then keep only that.
            S_FULL_RD: begin
                n_state = S_FULL_ACC;
            end

            S_FULL_ACC: begin
                n_acc = unit.joined;
                if ((r_i + CW'(1)) < r_count) begin
                    n_i     = r_i + CW'(1);
                    n_state = S_FULL_RD;
                end else begin
                    mem_we  = 1'b1;
                    mem_wa  = '0;
                    mem_wd  = unit.joined;
                    n_count = CW'(1);
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            // Clip one entry a pass; an empty one is replaced by the last entry.
            S_CLIP_RD: begin
                if (r_i < r_count) begin
                    rd_addr_b = cnt_m1[IW-1:0];
                    n_state   = S_CLIP_CHK;
                end else begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_CLIP_CHK: begin
                mem_we = 1'b1;
                if (unit.empty) begin
                    mem_wd  = r_rd_b;
                    n_count = cnt_m1;
                end else begin
                    mem_wd = unit.clamped;
                    n_i    = r_i + CW'(1);
                end
                n_state = S_CLIP_RD;
            end

            // Walk the pairs; on a touching pair unite them and restart the walk.
            S_MRG_RD: begin
                if (r_j < r_count) begin
                    n_state = S_MRG_CHK;
                end else begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_MRG_CHK: begin
                if (unit.near) begin
                    mem_we    = 1'b1;
                    mem_wd    = unit.joined;
                    rd_addr_a = cnt_m1[IW-1:0];
                    n_state   = S_MRG_MOVE;
                end else if ((r_j + CW'(1)) < r_count) begin
                    n_j     = r_j + CW'(1);
                    n_state = S_MRG_RD;
                end else begin
                    n_i     = r_i + CW'(1);
                    n_j     = r_i + CW'(2);
                    n_state = S_MRG_RD;
                end
            end

            S_MRG_MOVE: begin
                mem_we  = 1'b1;
                mem_wa  = r_j[IW-1:0];
                mem_wd  = r_rd_a;
                n_count = cnt_m1;
                n_i     = '0;
                n_j     = CW'(1);
                n_state = S_MRG_RD;
            end

            S_RD_OUT: begin
                res.entry_valid = r_flag;
                if (r_flag) begin
                    res.out_left   = r_rd_a.l;
                    res.out_top    = r_rd_a.t;
                    res.out_right  = r_rd_a.r;
                    res.out_bottom = r_rd_a.b;
                end
                done    = 1'b1;
                n_state = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        res.entry_count = 4'(n_count);
    end

    // State, pointers, count, flag and the held box.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_i     <= n_i;
            r_j     <= n_j;
            r_flag  <= n_flag;
        end
        r_acc <= n_acc;
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_count = r_count;
    assign o_done  = done;
    assign o_res   = res;

endmodule

// File: hw/rtl/dirty_rect_merge_table_top.sv
// Top level of the dirty rectangle table: configuration, command port and result register.
`timescale 1ns / 1ps

// Dirty rectangle table with merging.
// An item is taken at a rising edge where start is high and busy is low; busy stays
// high while the command runs. Each item gives one result, shown on o_result for
// exactly one cycle with o_strobe high; the receiver cannot stall it, so it must take
// the item in that cycle. A new item may be started in the cycle the strobe is high.
// Every command goes through one table memory port pair and one shared rectangle unit:
//   read looks up one slot; add rejects an inverted box, else scans the entries for a
//   touching one, else appends, or collapses a full table into one entry. clip visits
//   every entry; merge all tests pairs and restarts the walk after each pair united.
// The screen size is written through i_cfg_we, i_cfg_index and i_cfg_data at any edge;
// it should only change while busy is low and no result is pending.
// Reset empties the table and sets the screen to 320 by 240; no memory clearing pass
// is needed since entries at or above the count are never returned.
module dirty_rect_merge_table_top #(
    parameter int MAX_RECTS = drmt_pkg::MAX_RECTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  drmt_pkg::t_item   i_item,
    output logic              o_strobe,
    output drmt_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [14:0]       i_cfg_data
);

    localparam int CW = $clog2(MAX_RECTS + 1);

    logic [14:0]       r_width, r_height;
    logic              r_strobe;
    drmt_pkg::t_result r_result;
    logic              seq_busy, seq_done;
    logic [CW-1:0]     seq_count;
    drmt_pkg::t_result seq_res;
    logic              take;

    assign take = start && !seq_busy;

    // Screen size registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= drmt_pkg::WIDTH_RESET;
            r_height <= drmt_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                drmt_pkg::REG_WIDTH:  r_width  <= i_cfg_data;
                drmt_pkg::REG_HEIGHT: r_height <= i_cfg_data;
                default: begin
                    r_width <= r_width;
                end
            endcase
        end
    end

    drmt_seq #(
        .MAX_RECTS (MAX_RECTS),
        .CW        (CW)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (take),
        .i_item   (i_item),
        .i_width  (r_width),
        .i_height (r_height),
        .o_busy   (seq_busy),
        .o_count  (seq_count),
        .o_done   (seq_done),
        .o_res    (seq_res)
    );

    // Result register: one item per finished command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= seq_done;
        end
        if (seq_done) begin
            r_result <= seq_res;
        end
    end

    assign busy     = seq_busy;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

    // A taken item always keeps the sequencer busy in the next cycle.
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> busy)
        else $error("sequencer not busy after an item was taken");

    // A result is only shown once the sequencer has returned to idle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result shown while the sequencer is busy");

    // The count never exceeds the table depth.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(seq_count) <= MAX_RECTS)
        else $error("entry count beyond table depth");

    // An invalid read returns zero corners.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.entry_valid) |->
            (o_result.out_left == 16'sd0 && o_result.out_top == 16'sd0 &&
             o_result.out_right == 16'sd0 && o_result.out_bottom == 16'sd0))
        else $error("corners not zero on a result without a valid entry");

endmodule

// File: test/dirty_rect_merge_table_top_tb.sv
// Self-checking testbench for the dirty rectangle table: directed and random commands.
`timescale 1ns / 1ps

module dirty_rect_merge_table_top_tb;

    localparam int DEPTH       = drmt_pkg::MAX_RECTS_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 600;

    // Scoreboard: tracks the rectangle table and screen size, and holds expected results.
    class rect_board;
        drmt_pkg::t_box    boxes [DEPTH];
        int                live;
        int                scr_w;
        int                scr_h;
        drmt_pkg::t_result due [$];
        int                failures;

        function void clear_table();
            live     = 0;
            scr_w    = int'(drmt_pkg::WIDTH_RESET);
            scr_h    = int'(drmt_pkg::HEIGHT_RESET);
            failures = 0;
            due.delete();
        endfunction

        function void set_screen(int w, int h);
            scr_w = w;
            scr_h = h;
        endfunction

        // Overlap or adjacency test, evaluated at 32 bits so the minus one cannot wrap.
        function bit touches(drmt_pkg::t_box a, drmt_pkg::t_box b);
            return !(int'(a.r) < int'(b.l) - 1 || int'(a.l) > int'(b.r) + 1 ||
                     int'(a.b) < int'(b.t) - 1 || int'(a.t) > int'(b.b) + 1);
        endfunction

        function drmt_pkg::t_box unite(drmt_pkg::t_box a, drmt_pkg::t_box b);
            drmt_pkg::t_box u;
            u.l = (a.l < b.l) ? a.l : b.l;
            u.t = (a.t < b.t) ? a.t : b.t;
            u.r = (a.r > b.r) ? a.r : b.r;
            u.b = (a.b > b.b) ? a.b : b.b;
            return u;
        endfunction

        // Merge into the first touching entry, else append, else collapse a full table.
        function bit add_rect(drmt_pkg::t_box nb);
            if (nb.r < nb.l || nb.b < nb.t) return 1'b0;
            for (int i = 0; i < live; i++) begin
                if (touches(boxes[i], nb)) begin
                    boxes[i] = unite(boxes[i], nb);
                    return 1'b1;
                end
            end
            if (live >= DEPTH) begin
                boxes[0] = unite(boxes[0], nb);
                for (int i = 1; i < live; i++) boxes[0] = unite(boxes[0], boxes[i]);
                live = 1;
                return 1'b1;
            end
            boxes[live] = nb;
            live++;
            return 1'b1;
        endfunction

        // Clamp every entry to the screen; an emptied entry is replaced by the last one.
        function void clip_all();
            int k;
            k = 0;
            while (k < live) begin
                if (boxes[k].l < 0) boxes[k].l = '0;
                if (boxes[k].t < 0) boxes[k].t = '0;
                if (int'(boxes[k].r) >= scr_w) boxes[k].r = 16'(scr_w - 1);
                if (int'(boxes[k].b) >= scr_h) boxes[k].b = 16'(scr_h - 1);
                if (boxes[k].r < boxes[k].l || boxes[k].b < boxes[k].t) begin
                    boxes[k] = boxes[live - 1];
                    live--;
                end else begin
                    k++;
                end
            end
        endfunction

        // Unite the first touching pair and restart the walk until nothing touches.
        function void merge_pairs();
            bit changed;
            changed = 1'b1;
            while (changed) begin
                changed = 1'b0;
                for (int i = 0; i < live && !changed; i++) begin
                    for (int j = i + 1; j < live && !changed; j++) begin
                        if (touches(boxes[i], boxes[j])) begin
                            boxes[i] = unite(boxes[i], boxes[j]);
                            boxes[j] = boxes[live - 1];
                            live--;
                            changed = 1'b1;
                        end
                    end
                end
            end
        endfunction

        // Apply an accepted item to the table and queue the result it must produce.
        function void note_item(drmt_pkg::t_item it);
            drmt_pkg::t_result want;
            drmt_pkg::t_box    nb;
            want          = '0;
            want.accepted = 1'b1;
            case (it.command)
                drmt_pkg::CMD_ADD: begin
                    nb.l          = it.left;
                    nb.t          = it.top;
                    nb.r          = it.right;
                    nb.b          = it.bottom;
                    want.accepted = add_rect(nb);
                end
                drmt_pkg::CMD_CLIP:  clip_all();
                drmt_pkg::CMD_MERGE: merge_pairs();
                drmt_pkg::CMD_READ: begin
                    if (int'(it.slot) < live) begin
                        want.entry_valid = 1'b1;
                        want.out_left    = boxes[it.slot].l;
                        want.out_top     = boxes[it.slot].t;
                        want.out_right   = boxes[it.slot].r;
                        want.out_bottom  = boxes[it.slot].b;
                    end
                end
            endcase
            want.entry_count = 4'(live);
            due.push_back(want);
        endfunction

        function string describe(drmt_pkg::t_result v);
            return $sformatf("acc=%0d cnt=%0d vld=%0d box=(%0d,%0d,%0d,%0d)",
                             v.accepted, v.entry_count, v.entry_valid,
                             v.out_left, v.out_top, v.out_right, v.out_bottom);
        endfunction

        // Compare a strobed result with the oldest expectation.
        function void check_result(drmt_pkg::t_result got);
            drmt_pkg::t_result want;
            bit                bad;
            if (due.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("[%0t] result with nothing expected: %s", $realtime, describe(got));
                return;
            end
            want = due.pop_front();
            bad  = (got.accepted !== want.accepted) || (got.entry_count !== want.entry_count) ||
                   (got.entry_valid !== want.entry_valid) || (got.out_left !== want.out_left) ||
                   (got.out_top !== want.out_top) || (got.out_right !== want.out_right) ||
                   (got.out_bottom !== want.out_bottom);
            if (bad) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("[%0t] mismatch: expected %s, got %s",
                             $realtime, describe(want), describe(got));
            end
        endfunction
    endclass

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    drmt_pkg::t_item   i_item      = '0;
    logic              i_cfg_we    = 1'b0;
    logic              i_cfg_index = drmt_pkg::REG_WIDTH;
    logic [14:0]       i_cfg_data  = '0;
    logic              busy;
    logic              o_strobe;
    drmt_pkg::t_result o_result;

    rect_board   book;
    int          idle_pct = 0;
    int unsigned cycles   = 0;

    dirty_rect_merge_table_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("dirty_rect_merge_table_top regression: fail");
            $finish;
        end
    end

    // Result monitor; an unknown strobe is treated as a result so that it gets flagged.
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) book.check_result(o_result);
    end

    // Offer one item, raising start at random per cycle, until the block takes it.
    task automatic send_item(input drmt_pkg::t_item it);
        bit go;
        i_item <= it;
        do begin
            go = ($urandom_range(99) >= idle_pct);
            start <= go;
            @(posedge i_clk);
        end while (!(go && !busy));
        book.note_item(it);
    endtask

    // Wait until every expected result has come back.
    task automatic drain();
        while (book.due.size() != 0) @(posedge i_clk);
    endtask

    // Write both screen size registers on consecutive edges.
    task automatic write_screen(input logic [14:0] w, input logic [14:0] h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= drmt_pkg::REG_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= drmt_pkg::REG_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        book.set_screen(int'(w), int'(h));
    endtask

    function automatic drmt_pkg::t_item make_item(input logic [1:0] cmd, input int l,
                                                  input int t, input int r, input int b,
                                                  input int s);
        drmt_pkg::t_item it;
        it.command = cmd;
        it.left    = 16'(l);
        it.top     = 16'(t);
        it.right   = 16'(r);
        it.bottom  = 16'(b);
        it.slot    = 3'(s);
        return it;
    endfunction

    function automatic logic signed [15:0] pick_extreme();
        case ($urandom_range(5))
            0:       return 16'sh8000;
            1:       return 16'sh8001;
            2:       return 16'shFFFF;
            3:       return 16'sh0000;
            4:       return 16'sh7FFE;
            default: return 16'sh7FFF;
        endcase
    endfunction

    // Random item: adds, mostly small and clustered, so that merges and full tables are common.
    function automatic drmt_pkg::t_item random_item();
        drmt_pkg::t_item it;
        int              pick;
        int              spread;
        int              x;
        int              y;
        it.left   = 16'($urandom);
        it.top    = 16'($urandom);
        it.right  = 16'($urandom);
        it.bottom = 16'($urandom);
        it.slot   = 3'($urandom);
        pick      = $urandom_range(99);
        spread    = ($urandom_range(3) == 0) ? 4000 : 400;
        x         = int'($urandom_range(spread)) - 40;
        y         = int'($urandom_range(spread * 3 / 4)) - 30;
        if (pick < 55) begin
            it.command = drmt_pkg::CMD_ADD;
            case ($urandom_range(19))
                // Fully random corners, often inverted.
                0: ;
                // Deliberately inverted in one axis.
                1: begin
                    it.left   = 16'(x);
                    it.top    = 16'(y);
                    it.right  = 16'(x + int'($urandom_range(20)));
                    it.bottom = 16'(y + int'($urandom_range(20)));
                    if ($urandom_range(1)) it.right = 16'(x - 1 - int'($urandom_range(20)));
                    else                   it.bottom = 16'(y - 1 - int'($urandom_range(20)));
                end
                // Corners at the limits of the coordinate range.
                2: begin
                    it.left   = pick_extreme();
                    it.top    = pick_extreme();
                    it.right  = pick_extreme();
                    it.bottom = pick_extreme();
                end
                default: begin
                    it.left   = 16'(x);
                    it.top    = 16'(y);
                    it.right  = 16'(x + int'($urandom_range(30)));
                    it.bottom = 16'(y + int'($urandom_range(30)));
                end
            endcase
        end else if (pick < 80) begin
            it.command = drmt_pkg::CMD_READ;
        end else if (pick < 90) begin
            it.command = drmt_pkg::CMD_CLIP;
        end else begin
            it.command = drmt_pkg::CMD_MERGE;
        end
        return it;
    endfunction

    // One phase: settle, set the screen, then a burst of random items.
    task automatic run_phase(input logic [14:0] w, input logic [14:0] h,
                             input int pct, input int count);
        drain();
        write_screen(w, h);
        idle_pct = pct;
        repeat (count) send_item(random_item());
        start <= 1'b0;
    endtask

    initial begin
        book = new;
        book.clear_table();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset screen size of 320 by 240.
        send_item(make_item(drmt_pkg::CMD_READ, 0, 0, 0, 0, 0));
        send_item(make_item(drmt_pkg::CMD_ADD, 5, 0, 4, 9, 0));
        send_item(make_item(drmt_pkg::CMD_ADD, 0, 9, 9, 0, 0));
        send_item(make_item(drmt_pkg::CMD_ADD, 0, 0, 9, 9, 0));
        send_item(make_item(drmt_pkg::CMD_ADD, 10, 0, 20, 9, 0));
        send_item(make_item(drmt_pkg::CMD_ADD, 22, 0, 30, 9, 0));
        send_item(make_item(drmt_pkg::CMD_ADD, -32768, -32768, -32768, -32768, 0));
        send_item(make_item(drmt_pkg::CMD_ADD, 32767, 32767, 32767, 32767, 0));
        for (int k = 0; k < 4; k++)
            send_item(make_item(drmt_pkg::CMD_ADD, 100 + k * 20, 100, 105 + k * 20, 105, 0));
        // The table is full now, so this add collapses everything into one entry.
        send_item(make_item(drmt_pkg::CMD_ADD, 200, 200, 210, 210, 0));
        send_item(make_item(drmt_pkg::CMD_READ, 0, 0, 0, 0, 0));
        send_item(make_item(drmt_pkg::CMD_READ, 0, 0, 0, 0, 7));
        send_item(make_item(drmt_pkg::CMD_CLIP, 0, 0, 0, 0, 0));
        send_item(make_item(drmt_pkg::CMD_READ, 0, 0, 0, 0, 0));
        // Two separate entries that become adjacent through a third add.
        send_item(make_item(drmt_pkg::CMD_ADD, 500, 500, 510, 510, 0));
        send_item(make_item(drmt_pkg::CMD_ADD, 520, 500, 530, 510, 0));
        send_item(make_item(drmt_pkg::CMD_ADD, 511, 500, 519, 510, 0));
        send_item(make_item(drmt_pkg::CMD_MERGE, 0, 0, 0, 0, 0));
        send_item(make_item(drmt_pkg::CMD_READ, 0, 0, 0, 0, 1));
        send_item(make_item(drmt_pkg::CMD_CLIP, 0, 0, 0, 0, 0));
        send_item(make_item(drmt_pkg::CMD_MERGE, 0, 0, 0, 0, 0));
        send_item(make_item(drmt_pkg::CMD_ADD, -32768, -32768, 32767, 32767, 0));
        start <= 1'b0;

        // Random phases over several screen sizes, including the extremes and zero.
        run_phase(15'd32767, 15'd32767, 0, 300);
        run_phase(15'd1, 15'd32767, 83, 200);
        run_phase(15'd640, 15'd480, 28, 300);
        run_phase(15'd0, 15'd0, 0, 150);
        run_phase(15'd32767, 15'd1, 83, 200);
        run_phase(15'($urandom_range(1, 2000)), 15'($urandom_range(1, 2000)), 28, 375);

        // Let the last results arrive and watch for stray strobes.
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (book.failures == 0 && book.due.size() == 0)
            $display("dirty_rect_merge_table_top regression: pass");
        else
            $display("dirty_rect_merge_table_top regression: fail");
        $finish;
    end

endmodule
